// File: src/ljpe_pkg.sv
// Shared types and constants for the Lennard-Jones pair energy core.
// Holds the sequencer states, the product step codes, register indexes and reset values.
// No dependencies; every other file imports this package.
package ljpe_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int COUNT_BITS_DEF = 24;

    localparam int BOX_BITS       = 24;
    localparam int CFG_BITS       = 32;
    localparam int CFG_IDX_BITS   = 3;
    localparam int ENERGY_BITS    = 48;
    localparam int OUT_COUNT_BITS = 24;
    localparam int R2_BITS        = 64;
    localparam int QUO_BITS       = 48;
    localparam int MUL_BITS       = 32;
    localparam int OP_BITS        = 2 * MUL_BITS;
    localparam int PROD_BITS      = 63;
    localparam int TERM_BITS      = 51;
    localparam int E6_LIM_BIT     = 49;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_X     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Y     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_BOX_Z     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CUTOFF_SQ = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SIGMA_SQ  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_FOUR_EPS  = 3'd5;

    localparam logic [BOX_BITS-1:0] BOX_RESET      = 24'd1739981;
    localparam logic [CFG_BITS-1:0] CUTOFF_RESET   = 32'd4734976;
    localparam logic [CFG_BITS-1:0] SIGMA_RESET    = 32'd757596;
    localparam logic [CFG_BITS-1:0] FOUR_EPS_RESET = 32'd179071285;

    // Product cap, 2^62
    localparam logic [PROD_BITS-1:0] PCAP = {1'b1, {(PROD_BITS-1){1'b0}}};

    localparam logic signed [ENERGY_BITS-1:0] ENERGY_MAX = {1'b0, {(ENERGY_BITS-1){1'b1}}};
    localparam logic signed [ENERGY_BITS-1:0] ENERGY_MIN = {1'b1, {(ENERGY_BITS-1){1'b0}}};
    localparam logic signed [TERM_BITS-1:0]   TERM_MAX   =
        {{(TERM_BITS-ENERGY_BITS){1'b0}}, ENERGY_MAX};

    // Partial product order inside one capped Q.32 product
    localparam logic [1:0] PP_LL = 2'd0;
    localparam logic [1:0] PP_HH = 2'd3;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_CLASSIFY,
        ST_DIV,
        ST_MUL,
        ST_MACC,
        ST_TERM,
        ST_ADD,
        ST_FINISH
    } ljpe_state_t;

    // Chained products: s^2, s^3, 4eps*s^3, e3*s^3
    typedef enum logic [1:0] {
        MOP_S2,
        MOP_S3,
        MOP_E3,
        MOP_E6
    } ljpe_mop_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ljpe_div_stat_t;

endpackage

// File: src/ljpe_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Used for the axis squares and for every partial product of the power chain.
// Depends on ljpe_pkg.
module ljpe_mul
    import ljpe_pkg::*;
(
    input  logic                aclk,
    input  logic                mul_en,
    input  logic [MUL_BITS-1:0] mul_a,
    input  logic [MUL_BITS-1:0] mul_b,
    output logic [OP_BITS-1:0]  mul_prod
);

    logic [OP_BITS-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign mul_prod = prod_reg;

endmodule

// File: src/ljpe_div.sv
// Restoring divider, one quotient bit per cycle: sigma_sq * 2^48 / r^2.
// Caller guarantees sigma_sq < r^2, so the quotient fits in 48 bits.
// Depends on ljpe_pkg.
module ljpe_div
    import ljpe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 div_start,
    input  logic [CFG_BITS-1:0]  div_sigma,
    input  logic [R2_BITS-1:0]   div_r2,
    output ljpe_div_stat_t       div_stat,
    output logic [QUO_BITS-1:0]  div_quo
);

    localparam int CNT_W = $clog2(QUO_BITS + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [R2_BITS-1:0] rem_reg, rem_next;
    logic [R2_BITS-1:0] dvs_reg, dvs_next;
    logic [QUO_BITS-1:0] quo_reg, quo_next;

    logic [R2_BITS:0]   rem_sh;
    logic [R2_BITS:0]   rem_sub;
    logic               take;

    always_comb begin
        rem_sh  = {rem_reg, 1'b0};
        rem_sub = rem_sh - {1'b0, dvs_reg};
        take    = (rem_sh >= {1'b0, dvs_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;

        if (div_start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_BITS);
            rem_next  = R2_BITS'(div_sigma);
            dvs_next  = div_r2;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = take ? rem_sub[R2_BITS-1:0] : rem_sh[R2_BITS-1:0];
            quo_next = {quo_reg[QUO_BITS-2:0], take};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign div_stat.busy = busy_reg;
    assign div_stat.done = done_reg;
    assign div_quo       = quo_reg;

endmodule

// File: src/lj_pair_energy_min_image_core.sv
// Lennard-Jones 12-6 pair energy accumulator with minimum-image wrap.
// Channels: s_* takes one atom pair per transaction (valid/ready); m_* returns
// the energy sum, pair count and overlap flag once per pair marked last.
// Configuration: cfg_wr_en/cfg_index/cfg_wdata write box lengths, cutoff^2,
// sigma^2 and 4*epsilon; write only while the core is idle.
// Timing: one pair at a time, s_ready is high only in the idle state.
//   Pairs outside the cutoff or at zero separation go straight to the finish state.
//   Pairs with 4*epsilon zero or sigma^2 >= r^2 skip the divider and the products.
//   Other pairs inside the cutoff run the 48-step bit-serial divider, then
//   16 passes through the shared 32x32 multiplier, each pass a multiply
//   and then an accumulate.
// A last pair raises m_valid from the finish state once the sum is final. The result
// sits in an output register; the core keeps taking pairs while it waits,
// and only a following last pair stalls until m_ready frees the register.
// Reset (aresetn, synchronous, active low) clears the sum, count, flag and
// output valid, and loads the default register values.
// Depends on ljpe_pkg, ljpe_mul, ljpe_div.
module lj_pair_energy_min_image_core
    import ljpe_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_BITS-1:0]           cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [COORD_BITS-1:0]         s_first_x,
    input  logic [COORD_BITS-1:0]         s_first_y,
    input  logic [COORD_BITS-1:0]         s_first_z,
    input  logic [COORD_BITS-1:0]         s_second_x,
    input  logic [COORD_BITS-1:0]         s_second_y,
    input  logic [COORD_BITS-1:0]         s_second_z,
    input  logic                          s_last_pair,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [ENERGY_BITS-1:0] m_total_energy,
    output logic [OUT_COUNT_BITS-1:0]     m_pair_count,
    output logic                          m_overlap_seen
);

    localparam int DW = COORD_BITS + 3;
    localparam int BW = (COORD_BITS > BOX_BITS) ? COORD_BITS : BOX_BITS;
    localparam int CW = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

    // Control and configuration
    ljpe_state_t         state_reg, state_next;
    logic [BOX_BITS-1:0] box_x_reg, box_y_reg, box_z_reg;
    logic [CFG_BITS-1:0] cutoff_reg, sigma_reg, four_eps_reg;
    logic [1:0]          axis_reg, axis_next;
    ljpe_mop_t           mop_reg, mop_next;
    logic [1:0]          pp_reg, pp_next;

    logic signed [ENERGY_BITS-1:0] energy_reg, energy_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic                          overlap_reg, overlap_next;

    logic                          m_valid_reg, m_valid_next;
    logic signed [ENERGY_BITS-1:0] m_energy_reg, m_energy_next;
    logic [OUT_COUNT_BITS-1:0]     m_count_reg, m_count_next;
    logic                          m_overlap_reg, m_overlap_next;

    // Datapath
    logic [COORD_BITS-1:0] pa_reg [3];
    logic [COORD_BITS-1:0] pb_reg [3];
    logic                  last_reg;
    logic [R2_BITS-1:0]    r2_reg, r2_next;
    logic [PROD_BITS-1:0]  acc_reg, acc_next;
    logic [QUO_BITS-1:0]   s_reg, s_next;
    logic [PROD_BITS-1:0]  p_reg, p_next;
    logic [PROD_BITS-1:0]  e3_reg, e3_next;
    logic signed [TERM_BITS-1:0] term_reg, term_next;

    // Wrap logic
    logic [COORD_BITS-1:0]       p1_sel, p2_sel;
    logic [BOX_BITS-1:0]         box_sel;
    logic [BW-1:0]               box_w;
    logic signed [COORD_BITS:0]  d_diff;
    logic signed [DW-1:0]        d_ext, d_twice, bx_ext, d_wrap, d_mag;

    // Multiplier and product accumulate
    logic                  mul_en;
    logic [MUL_BITS-1:0]   mul_a, mul_b;
    logic [OP_BITS-1:0]    mul_prod;
    logic [OP_BITS-1:0]    op_a, op_b;
    logic [OP_BITS-1:0]    addend;
    logic [PROD_BITS-1:0]  acc_base;
    logic [OP_BITS:0]      acc_sum;
    logic [R2_BITS:0]      r2_sum;

    logic                  div_start;
    ljpe_div_stat_t        div_stat;
    logic [QUO_BITS-1:0]   div_quo;

    logic signed [ENERGY_BITS+3:0] e_sum;
    logic [CW-1:0]                 count_w;
    logic                          out_free;
    logic                          in_take;

    assign in_take  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign count_w  = CW'(count_reg);

    // Minimum image on the selected axis
    always_comb begin
        p1_sel = pa_reg[axis_reg];
        p2_sel = pb_reg[axis_reg];
        case (axis_reg)
            2'd0:    box_sel = box_x_reg;
            2'd1:    box_sel = box_y_reg;
            default: box_sel = box_z_reg;
        endcase
        box_w   = BW'(box_sel);
        d_diff  = $signed({1'b0, p2_sel}) - $signed({1'b0, p1_sel});
        d_ext   = {{2{d_diff[COORD_BITS]}}, d_diff};
        d_twice = {d_ext[DW-2:0], 1'b0};
        bx_ext  = {3'b000, box_w[COORD_BITS-1:0]};
        if (d_twice > bx_ext) begin
            d_wrap = d_ext - bx_ext;
        end else if (d_twice <= -bx_ext) begin
            d_wrap = d_ext + bx_ext;
        end else begin
            d_wrap = d_ext;
        end
        d_mag = d_wrap[DW-1] ? -d_wrap : d_wrap;
    end

    // Operand select for the product chain
    always_comb begin
        case (mop_reg)
            MOP_S2: begin
                op_a = OP_BITS'(s_reg);
                op_b = OP_BITS'(s_reg);
            end
            MOP_S3: begin
                op_a = OP_BITS'(p_reg);
                op_b = OP_BITS'(s_reg);
            end
            MOP_E3: begin
                op_a = OP_BITS'(four_eps_reg);
                op_b = OP_BITS'(p_reg);
            end
            default: begin
                op_a = OP_BITS'(e3_reg);
                op_b = OP_BITS'(p_reg);
            end
        endcase

        mul_en = (state_reg == ST_SQ_MUL) || (state_reg == ST_MUL);
        if (state_reg == ST_SQ_MUL) begin
            mul_a = MUL_BITS'(d_mag[COORD_BITS-1:0]);
            mul_b = MUL_BITS'(d_mag[COORD_BITS-1:0]);
        end else begin
            mul_a = pp_reg[1] ? op_a[OP_BITS-1:MUL_BITS] : op_a[MUL_BITS-1:0];
            mul_b = pp_reg[0] ? op_b[OP_BITS-1:MUL_BITS] : op_b[MUL_BITS-1:0];
        end
    end

    // Capped accumulate of one partial product
    always_comb begin
        if (pp_reg == PP_LL) begin
            addend = OP_BITS'(mul_prod[OP_BITS-1:MUL_BITS]);
        end else if (pp_reg == PP_HH) begin
            if (mul_prod[OP_BITS-1:PROD_BITS-MUL_BITS-1] != '0) begin
                addend = OP_BITS'(PCAP);
            end else begin
                addend = {mul_prod[MUL_BITS-1:0], {MUL_BITS{1'b0}}};
            end
        end else begin
            addend = mul_prod;
        end
        acc_base = (pp_reg == PP_LL) ? '0 : acc_reg;
        acc_sum  = {{(OP_BITS+1-PROD_BITS){1'b0}}, acc_base} + {1'b0, addend};
        if (acc_sum[OP_BITS:PROD_BITS-1] != '0) begin
            acc_next = PCAP;
        end else begin
            acc_next = acc_sum[PROD_BITS-1:0];
        end
        r2_sum = {1'b0, r2_reg} + {1'b0, mul_prod};
        e_sum  = {{4{energy_reg[ENERGY_BITS-1]}}, energy_reg}
               + {{(ENERGY_BITS+4-TERM_BITS){term_reg[TERM_BITS-1]}}, term_reg};
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        mop_next       = mop_reg;
        pp_next        = pp_reg;
        r2_next        = r2_reg;
        s_next         = s_reg;
        p_next         = p_reg;
        e3_next        = e3_reg;
        term_next      = term_reg;
        energy_next    = energy_reg;
        count_next     = count_reg;
        overlap_next   = overlap_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_energy_next  = m_energy_reg;
        m_count_next   = m_count_reg;
        m_overlap_next = m_overlap_reg;
        div_start      = 1'b0;
        s_ready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    axis_next  = '0;
                    r2_next    = '0;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                state_next = ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
                r2_next = r2_sum[R2_BITS] ? '1 : r2_sum[R2_BITS-1:0];
                if (axis_reg == AXIS_LAST) begin
                    state_next = ST_CLASSIFY;
                end else begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = ST_SQ_MUL;
                end
            end
            ST_CLASSIFY: begin
                if (r2_reg == '0) begin
                    overlap_next = 1'b1;
                    state_next   = ST_FINISH;
                end else if (r2_reg < {16'd0, cutoff_reg, 16'd0}) begin
                    if (count_reg != '1) begin
                        count_next = count_reg + COUNT_BITS'(1);
                    end
                    if (four_eps_reg == '0) begin
                        term_next  = '0;
                        state_next = ST_ADD;
                    end else if (R2_BITS'(sigma_reg) >= r2_reg) begin
                        // s would reach 2^16: clamp the term
                        term_next  = TERM_MAX;
                        state_next = ST_ADD;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    s_next     = div_quo;
                    mop_next   = MOP_S2;
                    pp_next    = PP_LL;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_MACC;
            end
            ST_MACC: begin
                if (pp_reg != PP_HH) begin
                    pp_next    = pp_reg + 2'd1;
                    state_next = ST_MUL;
                end else begin
                    pp_next = PP_LL;
                    case (mop_reg)
                        MOP_S2: begin
                            p_next     = acc_next;
                            mop_next   = MOP_S3;
                            state_next = ST_MUL;
                        end
                        MOP_S3: begin
                            p_next     = acc_next;
                            mop_next   = MOP_E3;
                            state_next = ST_MUL;
                        end
                        MOP_E3: begin
                            e3_next    = acc_next;
                            mop_next   = MOP_E6;
                            state_next = ST_MUL;
                        end
                        default: begin
                            state_next = ST_TERM;
                        end
                    endcase
                end
            end
            ST_TERM: begin
                // acc holds e6 here
                if (acc_reg[PROD_BITS-1:E6_LIM_BIT] != '0) begin
                    term_next = TERM_MAX;
                end else begin
                    term_next = $signed({1'b0, acc_reg[E6_LIM_BIT-1:0]})
                              - $signed({1'b0, e3_reg[E6_LIM_BIT-1:0]});
                end
                state_next = ST_ADD;
            end
            ST_ADD: begin
                if (e_sum > $signed({{4{1'b0}}, ENERGY_MAX})) begin
                    energy_next = ENERGY_MAX;
                end else if (e_sum < $signed({{4{1'b1}}, ENERGY_MIN})) begin
                    energy_next = ENERGY_MIN;
                end else begin
                    energy_next = e_sum[ENERGY_BITS-1:0];
                end
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    // Hand off the result and start a fresh set
                    m_valid_next   = 1'b1;
                    m_energy_next  = energy_reg;
                    m_count_next   = count_w[OUT_COUNT_BITS-1:0];
                    m_overlap_next = overlap_reg;
                    energy_next    = '0;
                    count_next     = '0;
                    overlap_next   = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            box_x_reg    <= BOX_RESET;
            box_y_reg    <= BOX_RESET;
            box_z_reg    <= BOX_RESET;
            cutoff_reg   <= CUTOFF_RESET;
            sigma_reg    <= SIGMA_RESET;
            four_eps_reg <= FOUR_EPS_RESET;
            axis_reg     <= '0;
            mop_reg      <= MOP_S2;
            pp_reg       <= PP_LL;
            energy_reg   <= '0;
            count_reg    <= '0;
            overlap_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            axis_reg    <= axis_next;
            mop_reg     <= mop_next;
            pp_reg      <= pp_next;
            energy_reg  <= energy_next;
            count_reg   <= count_next;
            overlap_reg <= overlap_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BOX_X:     box_x_reg    <= cfg_wdata[BOX_BITS-1:0];
                    REG_BOX_Y:     box_y_reg    <= cfg_wdata[BOX_BITS-1:0];
                    REG_BOX_Z:     box_z_reg    <= cfg_wdata[BOX_BITS-1:0];
                    REG_CUTOFF_SQ: cutoff_reg   <= cfg_wdata;
                    REG_SIGMA_SQ:  sigma_reg    <= cfg_wdata;
                    REG_FOUR_EPS:  four_eps_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            pa_reg[0] <= s_first_x;
            pa_reg[1] <= s_first_y;
            pa_reg[2] <= s_first_z;
            pb_reg[0] <= s_second_x;
            pb_reg[1] <= s_second_y;
            pb_reg[2] <= s_second_z;
            last_reg  <= s_last_pair;
        end
        if (state_reg == ST_MACC) begin
            acc_reg <= acc_next;
        end
        r2_reg        <= r2_next;
        s_reg         <= s_next;
        p_reg         <= p_next;
        e3_reg        <= e3_next;
        term_reg      <= term_next;
        m_energy_reg  <= m_energy_next;
        m_count_reg   <= m_count_next;
        m_overlap_reg <= m_overlap_next;
    end

    ljpe_mul u_mul (
        .aclk     (aclk),
        .mul_en   (mul_en),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .mul_prod (mul_prod)
    );

    ljpe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .div_start (div_start),
        .div_sigma (sigma_reg),
        .div_r2    (r2_reg),
        .div_stat  (div_stat),
        .div_quo   (div_quo)
    );

    assign m_valid        = m_valid_reg;
    assign m_total_energy = m_energy_reg;
    assign m_pair_count   = m_count_reg;
    assign m_overlap_seen = m_overlap_reg;

`ifndef SYNTHESIS
    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && $rose(m_valid_reg) |-> $past(state_reg == ST_FINISH && last_reg))
        else $error("result raised without a finished last pair");

    a_clear_after_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && last_reg && out_free)
        |=> (energy_reg == '0 && count_reg == '0 && !overlap_reg))
        else $error("accumulators not cleared after result");

    a_div_in_div_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide state");

    a_count_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (count_reg != $past(count_reg))
        |-> ($past(state_reg) == ST_CLASSIFY || $past(state_reg) == ST_FINISH))
        else $error("pair count changed outside classify or emit");
`endif

endmodule
